/* hw/rtl/oaht_pkg.sv */
// ----------------------------------------------------------------------------
// Open-addressing hash table package
// Shared field widths, command, status, flag and register codes, and the
// packed item types that travel between the parts of the table.
// ----------------------------------------------------------------------------
package oaht_pkg;

   localparam int TABLE_DEPTH = 1024;

   localparam int KEY_W      = 64;
   localparam int ID_W       = 16;
   localparam int HASH_W     = 32;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 3;
   localparam int SLOT_IDX_W = 10;
   localparam int CAP_W      = 11;
   localparam int POL_W      = 2;
   localparam int CNT_W      = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;

   localparam logic [POL_W-1:0] POL_QUAD   = 2'd1;
   localparam logic [POL_W-1:0] POL_DOUBLE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ID_RANGE  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 3'd4;

   localparam logic [1:0] FLAG_EMPTY = 2'd0;
   localparam logic [1:0] FLAG_LIVE  = 2'd1;
   localparam logic [1:0] FLAG_TOMB  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ID   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ID   = 3'd3;

   localparam logic [CAP_W-1:0] CAP_RESET    = 11'd1021;
   localparam logic [POL_W-1:0] POL_RESET    = 2'd0;
   localparam logic [ID_W-1:0]  MIN_ID_RESET = 16'd0;
   localparam logic [ID_W-1:0]  MAX_ID_RESET = 16'hFFFF;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [KEY_W-1:0]  key;
      logic [HASH_W-1:0] hashed_key;
      logic [ID_W-1:0]   entry_id;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic                  found;
      logic [SLOT_IDX_W-1:0] slot_index;
      logic                  rebuilt;
   } rsp_type;

   // Classified item handed from the front to the back.
   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [KEY_W-1:0]  key;
      logic [HASH_W-1:0] hashed_key;
      logic [ID_W-1:0]   entry_id;
      logic [CAP_W-1:0]  base;
      logic [CAP_W-1:0]  dstep;
      logic              id_bad;
   } work_type;

   // Payload of one table slot.
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [ID_W-1:0]   id;
      logic [HASH_W-1:0] hash;
   } entry_type;

endpackage

/* hw/rtl/oaht_reduce.sv */
// ----------------------------------------------------------------------------
// Hash reducer
// Serial remainder unit: hash mod capacity and the double-hash step
// (11 minus hash mod 11) reduced mod capacity, two hash bits per cycle.
// ----------------------------------------------------------------------------
module oaht_reduce
   import oaht_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [HASH_W-1:0] hash,
   input  logic [CAP_W-1:0]  cap,
   output logic              done,
   output logic [CAP_W-1:0]  base,
   output logic [CAP_W-1:0]  dstep
);

   localparam int DIV_STEPS = HASH_W / 2;
   localparam int RCNT_W    = $clog2(DIV_STEPS);
   localparam logic [3:0] DH_PRIME = 4'd11;

   typedef enum logic [2:0] {
      R_IDLE = 3'b001,
      R_DIV  = 3'b010,
      R_STEP = 3'b100
   } red_state_type;

   red_state_type      state_ff, state_in;
   logic [HASH_W-1:0]  shift_ff, shift_in;
   logic [CAP_W-1:0]   rc_ff, rc_in, rc_mid, rc_nxt;
   logic [3:0]         r11_ff, r11_in, r11_mid, r11_nxt;
   logic [3:0]         step_ff, step_in;
   logic [RCNT_W-1:0]  cnt_ff, cnt_in;
   logic               done_ff, done_in;

   function automatic logic [CAP_W-1:0] cap_step(input logic [CAP_W-1:0] r, input logic b,
                                                 input logic [CAP_W-1:0] d);
      logic [CAP_W:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) t = t - {1'b0, d};
      return t[CAP_W-1:0];
   endfunction

   function automatic logic [3:0] prime_step(input logic [3:0] r, input logic b);
      logic [4:0] t;
      t = {r, b};
      if (t >= {1'b0, DH_PRIME}) t = t - {1'b0, DH_PRIME};
      return t[3:0];
   endfunction

   assign rc_mid  = cap_step(rc_ff, shift_ff[HASH_W-1], cap);
   assign rc_nxt  = cap_step(rc_mid, shift_ff[HASH_W-2], cap);
   assign r11_mid = prime_step(r11_ff, shift_ff[HASH_W-1]);
   assign r11_nxt = prime_step(r11_mid, shift_ff[HASH_W-2]);

   always_comb begin
      state_in = state_ff;
      shift_in = shift_ff;
      rc_in    = rc_ff;
      r11_in   = r11_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         R_IDLE: begin
            if (start) begin
               shift_in = hash;
               rc_in    = '0;
               r11_in   = '0;
               cnt_in   = '0;
               state_in = R_DIV;
            end
         end
         R_DIV: begin
            shift_in = {shift_ff[HASH_W-3:0], 2'b00};
            rc_in    = rc_nxt;
            r11_in   = r11_nxt;
            cnt_in   = cnt_ff + RCNT_W'(1);
            if (cnt_ff == RCNT_W'(DIV_STEPS - 1)) begin
               step_in  = DH_PRIME - r11_nxt;
               state_in = R_STEP;
            end
         end
         R_STEP: begin
            // step is at most 11, so a few subtracts bring it below capacity
            if (CAP_W'(step_ff) >= cap) begin
               step_in = step_ff - cap[3:0];
            end else begin
               done_in  = 1'b1;
               state_in = R_IDLE;
            end
         end
         default: state_in = R_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rc_ff    <= rc_in;
      r11_ff   <= r11_in;
      step_ff  <= step_in;
      cnt_ff   <= cnt_in;
   end

   assign done  = done_ff;
   assign base  = rc_ff;
   assign dstep = CAP_W'(step_ff);

endmodule

/* hw/rtl/oaht_fifo.sv */
// ----------------------------------------------------------------------------
// Small queue
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module oaht_fifo #(
   parameter int  DEPTH     = 2,
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type pop_data
);

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   item_type           entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == COUNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = entries_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/oaht_front.sv */
// ----------------------------------------------------------------------------
// Hash table front end
// Accepts items, checks the insert ID range and reduces the hash into the
// probe base and double-hash step, then queues the item for the back end.
// ----------------------------------------------------------------------------
module oaht_front
   import oaht_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             hold,
   input  logic             req_push,
   output logic             req_full,
   input  req_type          req_data,
   input  logic [CAP_W-1:0] cap,
   input  logic [ID_W-1:0]  min_id,
   input  logic [ID_W-1:0]  max_id,
   output logic             wq_push,
   output work_type         wq_item,
   input  logic             wq_full
);

   typedef enum logic [2:0] {
      F_IDLE   = 3'b001,
      F_REDUCE = 3'b010,
      F_PUSH   = 3'b100
   } front_state_type;

   front_state_type  state_ff, state_in;
   req_type          item_ff, item_in;
   logic             bad_ff, bad_in;
   logic             accept;
   logic             red_done;
   logic [CAP_W-1:0] red_base, red_dstep;

   assign req_full = (state_ff != F_IDLE) | hold;
   assign accept   = req_push & ~req_full;

   oaht_reduce u_reduce (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .hash  (req_data.hashed_key),
      .cap   (cap),
      .done  (red_done),
      .base  (red_base),
      .dstep (red_dstep)
   );

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      bad_in   = bad_ff;
      wq_push  = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               item_in  = req_data;
               bad_in   = (req_data.entry_id < min_id) | (req_data.entry_id > max_id);
               state_in = F_REDUCE;
            end
         end
         F_REDUCE: begin
            if (red_done) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!wq_full) begin
               wq_push  = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      wq_item.command    = item_ff.command;
      wq_item.key        = item_ff.key;
      wq_item.hashed_key = item_ff.hashed_key;
      wq_item.entry_id   = item_ff.entry_id;
      wq_item.base       = red_base;
      wq_item.dstep      = red_dstep;
      wq_item.id_bad     = bad_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      bad_ff  <= bad_in;
   end

endmodule

/* hw/rtl/oaht_back.sv */
// ----------------------------------------------------------------------------
// Hash table back end
// Owns the slot memories and counters: walks probe sequences, applies
// insert, remove and lookup, and rebuilds into the other bank on demand.
// ----------------------------------------------------------------------------
module oaht_back
   import oaht_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [CAP_W-1:0] cap,
   input  logic [POL_W-1:0] policy,
   input  logic             wq_empty,
   input  work_type         wq_item,
   output logic             wq_pop,
   input  logic             rq_full,
   output logic             rq_push,
   output rsp_type          rq_item,
   output logic             clearing
);

   localparam int SLOT_W    = $clog2(TABLE_DEPTH);
   localparam int AW        = SLOT_W + 1;
   localparam int MEM_DEPTH = 2 * TABLE_DEPTH;

   typedef enum logic [12:0] {
      B_CLEAR   = 13'h0001,
      B_IDLE    = 13'h0002,
      B_RD      = 13'h0004,
      B_EV      = 13'h0008,
      B_DECIDE  = 13'h0010,
      B_CHECK   = 13'h0020,
      B_RB_RD   = 13'h0040,
      B_RB_EV   = 13'h0080,
      B_RB_HASH = 13'h0100,
      B_RB_PRD  = 13'h0200,
      B_RB_PEV  = 13'h0400,
      B_RB_DONE = 13'h0800,
      B_RESP    = 13'h1000
   } back_state_type;

   logic [1:0] flag_mem [MEM_DEPTH];
   entry_type  data_mem [MEM_DEPTH];
   logic [1:0] flag_rd_ff;
   entry_type  data_rd_ff;

   back_state_type    state_ff, state_in;
   work_type          cur_ff, cur_in;
   logic [CAP_W-1:0]  pos_ff, pos_in, i_ff, i_in, qd_ff, qd_in, step_ff, step_in;
   logic              match_ff, match_in;
   logic [CAP_W-1:0]  mslot_ff, mslot_in, ff_slot_ff, ff_slot_in;
   logic              ff_ok_ff, ff_ok_in, ff_tomb_ff, ff_tomb_in;
   logic              bank_ff, bank_in;
   logic [CNT_W-1:0]  occ_ff, occ_in, tomb_ff, tomb_in, placed_ff, placed_in;
   logic [SLOT_W-1:0] scan_ff, scan_in;
   logic [AW-1:0]     clr_ff, clr_in;
   rsp_type           res_ff, res_in;
   entry_type         mv_ff, mv_in;

   logic [AW-1:0]    rd_addr, fl_waddr, dt_waddr;
   logic             fl_we, dt_we;
   logic [1:0]       fl_wdata;
   entry_type        dt_wdata;
   logic             rb_start, rb_done;
   logic [CAP_W-1:0] rb_base, rb_dstep;

   logic [CAP_W-1:0] inc, pos_next, qd_next;
   logic [CAP_W:0]   pos_sum, qd_sum;
   logic [CNT_W-1:0] live;
   logic             no_room, need_rebuild, i_last, scan_last, scan_in_cap;
   logic             is_hit;

   function automatic logic [AW-1:0] mk_addr(input logic b, input logic [CAP_W-1:0] p);
      return {b, SLOT_W'(p)};
   endfunction

   // Step along the probe sequence: every increment is already below capacity.
   assign inc = (policy == POL_QUAD)   ? qd_ff :
                (policy == POL_DOUBLE) ? step_ff : CAP_W'(1);
   assign pos_sum  = {1'b0, pos_ff} + {1'b0, inc};
   assign pos_next = (pos_sum >= {1'b0, cap}) ? CAP_W'(pos_sum - {1'b0, cap})
                                              : pos_sum[CAP_W-1:0];
   assign qd_sum   = {1'b0, qd_ff} + (CAP_W+1)'(2);
   assign qd_next  = (qd_sum >= {1'b0, cap}) ? CAP_W'(qd_sum - {1'b0, cap})
                                             : qd_sum[CAP_W-1:0];

   assign live    = (occ_ff > tomb_ff) ? occ_ff - tomb_ff : '0;
   assign no_room = {(CNT_W+1)'(live) + (CNT_W+1)'(1), 1'b0} > (CNT_W+2)'(cap);
   assign need_rebuild = ({occ_ff, 1'b0} > (CNT_W+1)'(cap)) ||
                         (({1'b0, tomb_ff, 2'b00} + (CNT_W+3)'(tomb_ff)) >
                          {1'b0, occ_ff, 2'b00});

   assign i_last      = (i_ff == cap - CAP_W'(1));
   assign scan_last   = (scan_ff == SLOT_W'(TABLE_DEPTH - 1));
   assign scan_in_cap = (32'(scan_ff) < 32'(cap));
   assign is_hit      = (flag_rd_ff == FLAG_LIVE) && (data_rd_ff.key == cur_ff.key) &&
                        (data_rd_ff.id == cur_ff.entry_id);

   assign rd_addr = (state_ff == B_RB_RD)  ? {bank_ff, scan_ff} :
                    (state_ff == B_RB_PRD) ? mk_addr(~bank_ff, pos_ff) :
                                             mk_addr(bank_ff, pos_ff);

   oaht_reduce u_rb_reduce (
      .clock (clock),
      .reset (reset),
      .start (rb_start),
      .hash  (mv_in.hash),
      .cap   (cap),
      .done  (rb_done),
      .base  (rb_base),
      .dstep (rb_dstep)
   );

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      pos_in     = pos_ff;
      i_in       = i_ff;
      qd_in      = qd_ff;
      step_in    = step_ff;
      match_in   = match_ff;
      mslot_in   = mslot_ff;
      ff_ok_in   = ff_ok_ff;
      ff_slot_in = ff_slot_ff;
      ff_tomb_in = ff_tomb_ff;
      bank_in    = bank_ff;
      occ_in     = occ_ff;
      tomb_in    = tomb_ff;
      placed_in  = placed_ff;
      scan_in    = scan_ff;
      clr_in     = clr_ff;
      res_in     = res_ff;
      mv_in      = mv_ff;
      fl_we      = 1'b0;
      fl_waddr   = rd_addr;
      fl_wdata   = FLAG_EMPTY;
      dt_we      = 1'b0;
      dt_waddr   = rd_addr;
      dt_wdata   = mv_ff;
      rb_start   = 1'b0;
      wq_pop     = 1'b0;
      rq_push    = 1'b0;
      unique case (state_ff)
         B_CLEAR: begin
            fl_we    = 1'b1;
            fl_waddr = clr_ff;
            clr_in   = clr_ff + AW'(1);
            if (clr_ff == AW'(MEM_DEPTH - 1)) state_in = B_IDLE;
         end
         B_IDLE: begin
            if (!wq_empty) begin
               wq_pop   = 1'b1;
               cur_in   = wq_item;
               pos_in   = wq_item.base;
               step_in  = wq_item.dstep;
               i_in     = '0;
               qd_in    = CAP_W'(1);
               match_in = 1'b0;
               ff_ok_in = 1'b0;
               res_in   = '0;
               if (wq_item.command == CMD_INSERT && wq_item.id_bad) begin
                  res_in.status = ST_ID_RANGE;
                  state_in      = B_RESP;
               end else begin
                  state_in = B_RD;
               end
            end
         end
         B_RD: state_in = B_EV;
         B_EV: begin
            // remember the first slot an insert could take
            if (!ff_ok_ff && flag_rd_ff != FLAG_LIVE) begin
               ff_ok_in   = 1'b1;
               ff_slot_in = pos_ff;
               ff_tomb_in = (flag_rd_ff == FLAG_TOMB);
            end
            if (is_hit) begin
               match_in = 1'b1;
               mslot_in = pos_ff;
               state_in = B_DECIDE;
            end else if (flag_rd_ff == FLAG_EMPTY || i_last) begin
               state_in = B_DECIDE;
            end else begin
               pos_in   = pos_next;
               qd_in    = qd_next;
               i_in     = i_ff + CAP_W'(1);
               state_in = B_RD;
            end
         end
         B_DECIDE: begin
            if (cur_ff.command == CMD_INSERT) begin
               if (match_ff) begin
                  res_in.status = ST_DUPLICATE;
                  state_in      = B_RESP;
               end else if (no_room || !ff_ok_ff) begin
                  res_in.status = ST_NO_ROOM;
                  state_in      = B_RESP;
               end else begin
                  fl_we          = 1'b1;
                  fl_waddr       = mk_addr(bank_ff, ff_slot_ff);
                  fl_wdata       = FLAG_LIVE;
                  dt_we          = 1'b1;
                  dt_waddr       = mk_addr(bank_ff, ff_slot_ff);
                  dt_wdata.key   = cur_ff.key;
                  dt_wdata.id    = cur_ff.entry_id;
                  dt_wdata.hash  = cur_ff.hashed_key;
                  if (ff_tomb_ff && tomb_ff != '0) tomb_in = tomb_ff - CNT_W'(1);
                  occ_in            = occ_ff + CNT_W'(1);
                  res_in.slot_index = SLOT_IDX_W'(ff_slot_ff);
                  state_in          = B_CHECK;
               end
            end else if (!match_ff) begin
               res_in.status = ST_NOT_FOUND;
               state_in      = B_RESP;
            end else begin
               res_in.found      = 1'b1;
               res_in.slot_index = SLOT_IDX_W'(mslot_ff);
               if (cur_ff.command == CMD_REMOVE) begin
                  fl_we    = 1'b1;
                  fl_waddr = mk_addr(bank_ff, mslot_ff);
                  fl_wdata = FLAG_TOMB;
                  tomb_in  = tomb_ff + CNT_W'(1);
                  state_in = B_CHECK;
               end else begin
                  state_in = B_RESP;
               end
            end
         end
         B_CHECK: begin
            if (need_rebuild) begin
               res_in.rebuilt = 1'b1;
               scan_in        = '0;
               placed_in      = '0;
               state_in       = B_RB_RD;
            end else begin
               state_in = B_RESP;
            end
         end
         B_RB_RD: state_in = B_RB_EV;
         B_RB_EV: begin
            // drain the source slot; the old bank ends up all empty
            fl_we    = 1'b1;
            fl_waddr = {bank_ff, scan_ff};
            mv_in    = data_rd_ff;
            if (flag_rd_ff == FLAG_LIVE && scan_in_cap) begin
               rb_start = 1'b1;
               state_in = B_RB_HASH;
            end else if (scan_last) begin
               state_in = B_RB_DONE;
            end else begin
               scan_in  = scan_ff + SLOT_W'(1);
               state_in = B_RB_RD;
            end
         end
         B_RB_HASH: begin
            if (rb_done) begin
               pos_in   = rb_base;
               step_in  = rb_dstep;
               i_in     = '0;
               qd_in    = CAP_W'(1);
               state_in = B_RB_PRD;
            end
         end
         B_RB_PRD: state_in = B_RB_PEV;
         B_RB_PEV: begin
            if (flag_rd_ff == FLAG_EMPTY || i_last) begin
               if (flag_rd_ff == FLAG_EMPTY) begin
                  fl_we     = 1'b1;
                  fl_waddr  = mk_addr(~bank_ff, pos_ff);
                  fl_wdata  = FLAG_LIVE;
                  dt_we     = 1'b1;
                  dt_waddr  = mk_addr(~bank_ff, pos_ff);
                  placed_in = placed_ff + CNT_W'(1);
               end
               if (scan_last) begin
                  state_in = B_RB_DONE;
               end else begin
                  scan_in  = scan_ff + SLOT_W'(1);
                  state_in = B_RB_RD;
               end
            end else begin
               pos_in   = pos_next;
               qd_in    = qd_next;
               i_in     = i_ff + CAP_W'(1);
               state_in = B_RB_PRD;
            end
         end
         B_RB_DONE: begin
            bank_in  = ~bank_ff;
            occ_in   = placed_ff;
            tomb_in  = '0;
            state_in = B_RESP;
         end
         B_RESP: begin
            if (!rq_full) begin
               rq_push  = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
         bank_ff  <= 1'b0;
         occ_ff   <= '0;
         tomb_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         bank_ff  <= bank_in;
         occ_ff   <= occ_in;
         tomb_ff  <= tomb_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      pos_ff     <= pos_in;
      i_ff       <= i_in;
      qd_ff      <= qd_in;
      step_ff    <= step_in;
      match_ff   <= match_in;
      mslot_ff   <= mslot_in;
      ff_ok_ff   <= ff_ok_in;
      ff_slot_ff <= ff_slot_in;
      ff_tomb_ff <= ff_tomb_in;
      placed_ff  <= placed_in;
      scan_ff    <= scan_in;
      res_ff     <= res_in;
      mv_ff      <= mv_in;
   end

   always_ff @(posedge clock) begin
      if (fl_we) flag_mem[fl_waddr] <= fl_wdata;
      flag_rd_ff <= flag_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (dt_we) data_mem[dt_waddr] <= dt_wdata;
      data_rd_ff <= data_mem[rd_addr];
   end

   assign rq_item  = res_ff;
   assign clearing = (state_ff == B_CLEAR);

endmodule

/* hw/rtl/open_addressing_hash_table.sv */
// ----------------------------------------------------------------------------
// Open-addressing hash table
// Insert, remove and lookup of key/ID entries with tombstones and a
// two-bank tombstone purge, behind queue-style request and response ports.
// ----------------------------------------------------------------------------
// After reset the block sweeps both slot banks to empty with req_full held
// high; configuration writes are taken meanwhile. Each item then passes the
// front end, where a serial remainder unit takes two hash bits per cycle and
// then brings the double-hash step below capacity, followed by a handshake;
// this overlaps the back end working on the previous item. The back end
// spends a registered slot memory read and then a compare on each probe,
// plus its decide, check and response states. An insert or remove that trips
// the purge condition rebuilds into the other bank before its response
// appears: it scans every slot of the old bank, and for each live entry
// reduces the hash again and probes the new bank.
// Results come back in request order through a two-entry response queue.
// ----------------------------------------------------------------------------
module open_addressing_hash_table
   import oaht_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [CAP_W-1:0] cap_ff, cap_in, cap_eff;
   logic [POL_W-1:0] policy_ff, policy_in;
   logic [ID_W-1:0]  min_id_ff, min_id_in, max_id_ff, max_id_in;

   logic     wq_push, wq_full, wq_pop, wq_empty;
   work_type wq_in_item, wq_out_item;
   logic     rq_push, rq_full;
   rsp_type  rq_item;
   logic     clearing;

   // Hold each register until its index is written.
   always_comb begin
      cap_in    = cap_ff;
      policy_in = policy_ff;
      min_id_in = min_id_ff;
      max_id_in = max_id_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CAPACITY: cap_in    = csr_wdata[CAP_W-1:0];
            CSR_POLICY:   policy_in = csr_wdata[POL_W-1:0];
            CSR_MIN_ID:   min_id_in = csr_wdata[ID_W-1:0];
            CSR_MAX_ID:   max_id_in = csr_wdata[ID_W-1:0];
            default:      ; // drop writes beyond the register list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_RESET;
         policy_ff <= POL_RESET;
         min_id_ff <= MIN_ID_RESET;
         max_id_ff <= MAX_ID_RESET;
      end else begin
         cap_ff    <= cap_in;
         policy_ff <= policy_in;
         min_id_ff <= min_id_in;
         max_id_ff <= max_id_in;
      end
   end

   // Clamp capacity to at least 2 and at most the bank depth.
   always_comb begin
      if (cap_ff < CAP_W'(2)) begin
         cap_eff = CAP_W'(2);
      end else if (32'(cap_ff) > 32'(TABLE_DEPTH)) begin
         cap_eff = CAP_W'(TABLE_DEPTH);
      end else begin
         cap_eff = cap_ff;
      end
   end

   oaht_front u_front (
      .clock    (clock),
      .reset    (reset),
      .hold     (clearing),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cap      (cap_eff),
      .min_id   (min_id_ff),
      .max_id   (max_id_ff),
      .wq_push  (wq_push),
      .wq_item  (wq_in_item),
      .wq_full  (wq_full)
   );

   oaht_fifo #(
      .DEPTH     (2),
      .item_type (work_type)
   ) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (wq_push),
      .push_data (wq_in_item),
      .full      (wq_full),
      .pop       (wq_pop),
      .empty     (wq_empty),
      .pop_data  (wq_out_item)
   );

   oaht_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cap      (cap_eff),
      .policy   (policy_ff),
      .wq_empty (wq_empty),
      .wq_item  (wq_out_item),
      .wq_pop   (wq_pop),
      .rq_full  (rq_full),
      .rq_push  (rq_push),
      .rq_item  (rq_item),
      .clearing (clearing)
   );

   oaht_fifo #(
      .DEPTH     (2),
      .item_type (rsp_type)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_data (rq_item),
      .full      (rq_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_data)
   );

   // The back end only hands over a response when the queue has room.
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rq_push |-> !rq_full)
      else $error("response pushed into a full queue");

   // No item may enter while the banks are being swept after reset.
   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_full)
      else $error("request accepted during the clearing sweep");

   // The back end takes work only when some is queued.
   a_work_pop_valid: assert property (@(posedge clock) disable iff (reset)
      wq_pop |-> !wq_empty)
      else $error("work item popped from an empty queue");

endmodule
